@@ hw/rtl/gprb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gprb_pkg
// shared types and constants of the grip pressure band regulator
// ----------------------------------------------------------------------------
package gprb_pkg;

	// beat widths on the stream ports and widths of the config write port
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	// overheat threshold in degrees c
	localparam logic [7:0] HOT_LIMIT = 8'd75;
	// thermal disable goal magnitude, 0.5 rad in 1/8000 rad units
	localparam logic signed [15:0] DISABLE_GOAL = 16'sd4000;

	// register reset values
	localparam logic [12:0] LOWER_BAND_RST  = 13'd800;
	localparam logic [12:0] UPPER_BAND_RST  = 13'd1000;
	localparam logic [14:0] LEFT_LIMIT_RST  = 15'd8000;
	localparam logic [14:0] RIGHT_LIMIT_RST = 15'd8000;
	localparam logic [11:0] LEFT_ZERO_RST   = 12'd0;
	localparam logic [11:0] RIGHT_ZERO_RST  = 12'd130;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_THERMAL = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_SQUEEZE = 2'd3
	} cmd_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOWER_BAND  = 3'd0,
		REG_UPPER_BAND  = 3'd1,
		REG_LEFT_LIMIT  = 3'd2,
		REG_RIGHT_LIMIT = 3'd3,
		REG_LEFT_ZERO   = 3'd4,
		REG_RIGHT_ZERO  = 3'd5,
		REG_REG_ENABLE  = 3'd6,
		REG_GRIP_CLOSED = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [12:0] lower_band;
		logic [12:0] upper_band;
		logic [14:0] left_limit;
		logic [14:0] right_limit;
		logic [11:0] left_zero_sum;
		logic [11:0] right_zero_sum;
		logic        regulate_enable;
		logic        gripper_closed;
	} cfg_t;

	typedef struct packed {
		logic [9:0]         press_l0;
		logic [9:0]         press_l1;
		logic [9:0]         press_l2;
		logic [9:0]         press_l3;
		logic [9:0]         press_r0;
		logic [9:0]         press_r1;
		logic [9:0]         press_r2;
		logic [9:0]         press_r3;
		logic [7:0]         left_temp;
		logic [7:0]         right_temp;
		logic signed [15:0] left_target;
		logic signed [15:0] right_target;
	} in_item_t;

	typedef struct packed {
		logic [11:0]        left_total;
		logic [11:0]        right_total;
		logic [12:0]        grip_total;
		logic               overheated;
		cmd_kind_t          cmd_kind;
		logic signed [15:0] left_goal;
		logic signed [15:0] right_goal;
	} out_item_t;

endpackage
`default_nettype wire

@@ hw/rtl/gprb_calc.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gprb_calc
// per-tick pressure totals, overheat check and band regulation step
// ----------------------------------------------------------------------------
module gprb_calc
	import gprb_pkg::*;
(
	input  wire in_item_t  item,
	input  wire cfg_t      cfg,
	input  wire logic      latch_cur,
	output out_item_t      result,
	output logic           latch_next
);

	logic [11:0]        lsum, rsum;
	logic [11:0]        ltot, rtot;
	logic [12:0]        grip;
	logic               hot;
	logic               regulate;
	logic [12:0]        rel_step, sqz_step;
	logic signed [17:0] lcur, rcur, rel_s, sqz_s, llim, rlim;
	logic signed [17:0] l_rel_sum, r_rel_dif, l_sqz_dif, r_sqz_sum;
	logic signed [17:0] lg_rel, rg_rel, lg_sqz, rg_sqz;

	always_comb begin
		lsum = 12'(item.press_l0) + 12'(item.press_l1) + 12'(item.press_l2)
			+ 12'(item.press_l3);
		rsum = 12'(item.press_r0) + 12'(item.press_r1) + 12'(item.press_r2)
			+ 12'(item.press_r3);
		ltot = (lsum > cfg.left_zero_sum) ? lsum - cfg.left_zero_sum : 12'd0;
		rtot = (rsum > cfg.right_zero_sum) ? rsum - cfg.right_zero_sum : 12'd0;
		grip = 13'(ltot) + 13'(rtot);

		hot        = (item.left_temp >= HOT_LIMIT) || (item.right_temp >= HOT_LIMIT);
		latch_next = hot;
		regulate   = cfg.regulate_enable && cfg.gripper_closed && !hot;

		rel_step = grip - cfg.upper_band;
		sqz_step = cfg.lower_band - grip;
		lcur = 18'(item.left_target);
		rcur = 18'(item.right_target);
		rel_s = $signed({5'd0, rel_step});
		sqz_s = $signed({5'd0, sqz_step});
		llim = $signed({3'd0, cfg.left_limit});
		rlim = $signed({3'd0, cfg.right_limit});

		// release: open both fingers by the error, clamp at the limits
		l_rel_sum = lcur + rel_s;
		r_rel_dif = rcur - rel_s;
		lg_rel = (l_rel_sum < llim) ? l_rel_sum : llim;
		rg_rel = (r_rel_dif > -rlim) ? r_rel_dif : -rlim;

		// squeeze: close both fingers by the error, clamp at the limits
		l_sqz_dif = lcur - sqz_s;
		r_sqz_sum = rcur + sqz_s;
		lg_sqz = (l_sqz_dif > -llim) ? l_sqz_dif : -llim;
		rg_sqz = (r_sqz_sum < rlim) ? r_sqz_sum : rlim;

		result.left_total  = ltot;
		result.right_total = rtot;
		result.grip_total  = grip;
		result.overheated  = hot;
		result.cmd_kind    = CMD_NONE;
		result.left_goal   = '0;
		result.right_goal  = '0;

		if (hot && !latch_cur) begin
			result.cmd_kind   = CMD_THERMAL;
			result.left_goal  = -DISABLE_GOAL;
			result.right_goal = DISABLE_GOAL;
		end

		// release wins over squeeze when the band is inverted
		priority if (regulate && (grip > cfg.upper_band)) begin
			if ((lg_rel < llim) || (rg_rel > -rlim)) begin
				result.cmd_kind   = CMD_RELEASE;
				result.left_goal  = lg_rel[15:0];
				result.right_goal = rg_rel[15:0];
			end
		end else if (regulate && (grip < cfg.lower_band)) begin
			if ((lg_sqz > -llim) || (rg_sqz < rlim)) begin
				result.cmd_kind   = CMD_SQUEEZE;
				result.left_goal  = lg_sqz[15:0];
				result.right_goal = rg_sqz[15:0];
			end
		end else begin
			result.left_goal = result.left_goal;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/grip_pressure_band_regulator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// an accepted input beat goes through the input register and then the result register to the output
// throughput: one beat per cycle unless the output stalls; the two registers form a two-deep pipe
// while a result waits, an input beat is taken only if the input register is empty
// reset: arst_n clears valids and the overheat latch, config registers load defaults
// ----------------------------------------------------------------------------
// grip_pressure_band_regulator
// gripper pressure totals, overheat disable and pressure band regulation
// ----------------------------------------------------------------------------
module grip_pressure_band_regulator
	import gprb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// press_l0..l3, press_r0..r3 (10b each), left_temp, right_temp (8b),
	// left_target, right_target (16b signed)
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// output stream
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// left_total (12b), right_total (12b), grip_total (13b), overheated (1b),
	// left_goal (16b signed), right_goal (16b signed), 2b zero pad
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// cmd_kind (2b)
	output logic [OUT_USER_W-1:0]      m_axis_tuser
);

	cfg_t      cfg_q;
	in_item_t  in_s1;
	logic      valid_s1;
	out_item_t out_s2;
	logic      valid_s2;
	logic      latch_q;

	out_item_t calc_res;
	logic      latch_next;
	logic      adv_s1;
	logic      ready_s1;
	logic      take_in;

	// config registers; the user must write them only while the pipe is empty, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower_band      <= LOWER_BAND_RST;
			cfg_q.upper_band      <= UPPER_BAND_RST;
			cfg_q.left_limit      <= LEFT_LIMIT_RST;
			cfg_q.right_limit     <= RIGHT_LIMIT_RST;
			cfg_q.left_zero_sum   <= LEFT_ZERO_RST;
			cfg_q.right_zero_sum  <= RIGHT_ZERO_RST;
			cfg_q.regulate_enable <= 1'b0;
			cfg_q.gripper_closed  <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LOWER_BAND:  cfg_q.lower_band      <= cfg_data[12:0];
				REG_UPPER_BAND:  cfg_q.upper_band      <= cfg_data[12:0];
				REG_LEFT_LIMIT:  cfg_q.left_limit      <= cfg_data[14:0];
				REG_RIGHT_LIMIT: cfg_q.right_limit     <= cfg_data[14:0];
				REG_LEFT_ZERO:   cfg_q.left_zero_sum   <= cfg_data[11:0];
				REG_RIGHT_ZERO:  cfg_q.right_zero_sum  <= cfg_data[11:0];
				REG_REG_ENABLE:  cfg_q.regulate_enable <= cfg_data[0];
				REG_GRIP_CLOSED: cfg_q.gripper_closed  <= cfg_data[0];
				default:         cfg_q                 <= cfg_q;
			endcase
		end
	end

	// pipe handshake: stage 2 frees when empty or drained this cycle
	assign ready_s1      = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && ready_s1;
	assign s_axis_tready = !valid_s1 || ready_s1;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	// valids and the overheat latch are control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			latch_q  <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				// latch follows item order since stage 1 holds one item
				latch_q  <= latch_next;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// input register, unpacked from the beat lowest field first
	always_ff @(posedge clk) begin
		if (take_in) begin
			in_s1.press_l0     <= s_axis_tdata[9:0];
			in_s1.press_l1     <= s_axis_tdata[19:10];
			in_s1.press_l2     <= s_axis_tdata[29:20];
			in_s1.press_l3     <= s_axis_tdata[39:30];
			in_s1.press_r0     <= s_axis_tdata[49:40];
			in_s1.press_r1     <= s_axis_tdata[59:50];
			in_s1.press_r2     <= s_axis_tdata[69:60];
			in_s1.press_r3     <= s_axis_tdata[79:70];
			in_s1.left_temp    <= s_axis_tdata[87:80];
			in_s1.right_temp   <= s_axis_tdata[95:88];
			in_s1.left_target  <= s_axis_tdata[111:96];
			in_s1.right_target <= s_axis_tdata[127:112];
		end
	end

	gprb_calc u_calc (
		.item           (in_s1),
		.cfg            (cfg_q),
		.latch_cur      (latch_q),
		.result         (calc_res),
		.latch_next     (latch_next)
	);

	// result register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_s2 <= calc_res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, out_s2.right_goal, out_s2.left_goal, out_s2.overheated,
		out_s2.grip_total, out_s2.right_total, out_s2.left_total};
	assign m_axis_tuser  = out_s2.cmd_kind;

	// a thermal disable beat always reports the latch set
	a_thermal_hot: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (out_s2.cmd_kind == CMD_THERMAL)) |-> out_s2.overheated)
		else $error("thermal disable without overheat");

	// regulation never runs while overheated
	a_reg_cool: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ((out_s2.cmd_kind == CMD_RELEASE) || (out_s2.cmd_kind == CMD_SQUEEZE)))
		|-> !out_s2.overheated)
		else $error("regulation command while overheated");

	// a beat with no command carries zero goals
	a_idle_goals: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (out_s2.cmd_kind == CMD_NONE))
		|-> ((out_s2.left_goal == 16'sd0) && (out_s2.right_goal == 16'sd0)))
		else $error("goals nonzero without command");

	// latch register tracks the overheat bit held in the result register
	a_latch_track: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (latch_q == out_s2.overheated))
		else $error("overheat latch out of step with result");

	// grip total is the sum of the finger totals
	a_grip_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (out_s2.grip_total == (13'(out_s2.left_total) + 13'(out_s2.right_total))))
		else $error("grip total mismatch");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the grip pressure band regulator: sensor ticks go
// in on the input stream, a local model of the totals, the overheat latch
// and the band regulation predicts each result beat, and the monitor
// compares every field. registers change only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
	import gprb_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int HOLD_CYCLES = 60;
	localparam int TAIL_CYCLES = 10;
	localparam int RAND_PHASES = 14;
	localparam int PHASE_TICKS = 100;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	grip_pressure_band_regulator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// register copy and overheat latch of the local model
	cfg_t      regs_shadow;
	logic      heat_latch = 1'b0;

	in_item_t  tick_q[$];         // sensor ticks waiting to be driven
	out_item_t tick_results_q[$]; // predicted result beats, oldest first
	in_item_t  cur_tick;

	int        gap_pct = 0;
	int        stall_pct = 0;
	int        gap_left = 0;
	int        stall_left = 0;
	int        hold_left = 0;
	logic      hold_go = 1'b0;
	int        mismatches = 0;
	int        beats_seen = 0;
	int        cycle_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(string what, int got, int want);
		mismatches++;
		$display("mismatch at result beat %0d, %s: got %0d want %0d",
			beats_seen, what, got, want);
	endtask

	// append a tick to the pending queue
	task automatic enq_tick(in_item_t t);
		tick_q.insert(tick_q.size(), t);
	endtask

	// totals, overheat latch and band regulation for one tick
	function automatic out_item_t regulate_tick(in_item_t t);
		out_item_t r;
		int lsum, rsum, ltot, rtot, grip;
		int lcur, rcur, llim, rlim, lo_band, hi_band, step, lg, rg;
		lsum = int'(t.press_l0) + int'(t.press_l1) + int'(t.press_l2) + int'(t.press_l3);
		rsum = int'(t.press_r0) + int'(t.press_r1) + int'(t.press_r2) + int'(t.press_r3);
		ltot = lsum - int'(regs_shadow.left_zero_sum);
		rtot = rsum - int'(regs_shadow.right_zero_sum);
		if (ltot < 0) ltot = 0;
		if (rtot < 0) rtot = 0;
		grip = ltot + rtot;
		lcur = int'($signed(t.left_target));
		rcur = int'($signed(t.right_target));
		llim = int'(regs_shadow.left_limit);
		rlim = int'(regs_shadow.right_limit);
		lo_band = int'(regs_shadow.lower_band);
		hi_band = int'(regs_shadow.upper_band);

		r.cmd_kind = CMD_NONE;
		r.left_goal = '0;
		r.right_goal = '0;

		// one disable command on the rising edge of the latch only
		if (t.left_temp >= HOT_LIMIT || t.right_temp >= HOT_LIMIT) begin
			if (!heat_latch) begin
				r.cmd_kind = CMD_THERMAL;
				r.left_goal = -DISABLE_GOAL;
				r.right_goal = DISABLE_GOAL;
				heat_latch = 1'b1;
			end
		end else begin
			heat_latch = 1'b0;
		end

		if (regs_shadow.regulate_enable && regs_shadow.gripper_closed && !heat_latch) begin
			// release wins when the band is inverted
			if (grip > hi_band) begin
				step = grip - hi_band;
				lg = (lcur + step < llim) ? lcur + step : llim;
				rg = (rcur - step > -rlim) ? rcur - step : -rlim;
				if (lg < llim || rg > -rlim) begin
					r.cmd_kind = CMD_RELEASE;
					r.left_goal = 16'(lg);
					r.right_goal = 16'(rg);
				end
			end else if (grip < lo_band) begin
				step = lo_band - grip;
				lg = (lcur - step > -llim) ? lcur - step : -llim;
				rg = (rcur + step < rlim) ? rcur + step : rlim;
				if (lg > -llim || rg < rlim) begin
					r.cmd_kind = CMD_SQUEEZE;
					r.left_goal = 16'(lg);
					r.right_goal = 16'(rg);
				end
			end
		end

		r.left_total = 12'(ltot);
		r.right_total = 12'(rtot);
		r.grip_total = 13'(grip);
		r.overheated = heat_latch;
		return r;
	endfunction

	// directed tick: the four samples of a finger share one value
	function automatic in_item_t grip_tick(int lp, int rp, int lt, int rt, int ltg, int rtg);
		in_item_t t;
		t.press_l0 = 10'(lp);
		t.press_l1 = 10'(lp);
		t.press_l2 = 10'(lp);
		t.press_l3 = 10'(lp);
		t.press_r0 = 10'(rp);
		t.press_r1 = 10'(rp);
		t.press_r2 = 10'(rp);
		t.press_r3 = 10'(rp);
		t.left_temp = 8'(lt);
		t.right_temp = 8'(rt);
		t.left_target = 16'(ltg);
		t.right_target = 16'(rtg);
		return t;
	endfunction

	// mostly cool ticks near the band and near the limits, some full-range noise
	function automatic in_item_t random_tick();
		in_item_t t;
		int span, lim;
		span = ($urandom_range(0, 2) == 0) ? 1023 : $urandom_range(0, 400);
		t.press_l0 = 10'($urandom_range(0, span));
		t.press_l1 = 10'($urandom_range(0, span));
		t.press_l2 = 10'($urandom_range(0, span));
		t.press_l3 = 10'($urandom_range(0, span));
		t.press_r0 = 10'($urandom_range(0, span));
		t.press_r1 = 10'($urandom_range(0, span));
		t.press_r2 = 10'($urandom_range(0, span));
		t.press_r3 = 10'($urandom_range(0, span));
		if ($urandom_range(0, 9) == 0) begin
			t.left_temp = 8'($urandom_range(0, 255));
			t.right_temp = 8'($urandom_range(0, 255));
		end else begin
			t.left_temp = 8'($urandom_range(0, 74));
			t.right_temp = 8'($urandom_range(0, 74));
		end
		if ($urandom_range(0, 1) == 0) begin
			t.left_target = 16'($urandom);
			t.right_target = 16'($urandom);
		end else begin
			lim = regs_shadow.left_limit;
			t.left_target = 16'(int'($urandom_range(0, 2 * lim + 200)) - lim - 100);
			lim = regs_shadow.right_limit;
			t.right_target = 16'(int'($urandom_range(0, 2 * lim + 200)) - lim - 100);
		end
		return t;
	endfunction

	function automatic cfg_t pick_setting(int p);
		cfg_t s;
		int a;
		case (p)
			0: begin
				s.lower_band = 13'd8184;
				s.upper_band = 13'd8184;
				s.left_limit = 15'd32767;
				s.right_limit = 15'd32767;
				s.left_zero_sum = 12'd4092;
				s.right_zero_sum = 12'd4092;
			end
			1: begin
				s.lower_band = '0;
				s.upper_band = '0;
				s.left_limit = '0;
				s.right_limit = '0;
				s.left_zero_sum = '0;
				s.right_zero_sum = '0;
			end
			default: begin
				s.lower_band = 13'($urandom_range(0, 3000));
				s.upper_band = 13'(int'(s.lower_band) + int'($urandom_range(0, 800)));
				if ($urandom_range(0, 5) == 0) begin
					// inverted band
					a = s.lower_band;
					s.lower_band = s.upper_band;
					s.upper_band = 13'(a);
				end
				if ($urandom_range(0, 3) == 0) begin
					s.left_limit = $urandom_range(0, 1) ? 15'd32767 : 15'd0;
					s.right_limit = $urandom_range(0, 1) ? 15'd32767 : 15'd0;
				end else begin
					s.left_limit = 15'($urandom_range(500, 20000));
					s.right_limit = 15'($urandom_range(500, 20000));
				end
				if ($urandom_range(0, 5) == 0) begin
					s.left_zero_sum = 12'($urandom_range(0, 4092));
					s.right_zero_sum = 12'($urandom_range(0, 4092));
				end else begin
					s.left_zero_sum = 12'($urandom_range(0, 400));
					s.right_zero_sum = 12'($urandom_range(0, 400));
				end
			end
		endcase
		s.regulate_enable = (p < 2) || ($urandom_range(0, 3) != 0);
		s.gripper_closed = (p < 2) || ($urandom_range(0, 3) != 0);
		return s;
	endfunction

	task automatic put_reg(reg_idx_t idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
	endtask

	// only called with nothing in flight
	task automatic apply_setting(cfg_t s);
		put_reg(REG_LOWER_BAND, s.lower_band);
		put_reg(REG_UPPER_BAND, s.upper_band);
		put_reg(REG_LEFT_LIMIT, s.left_limit);
		put_reg(REG_RIGHT_LIMIT, s.right_limit);
		put_reg(REG_LEFT_ZERO, s.left_zero_sum);
		put_reg(REG_RIGHT_ZERO, s.right_zero_sum);
		put_reg(REG_REG_ENABLE, s.regulate_enable);
		put_reg(REG_GRIP_CLOSED, s.gripper_closed);
		@(posedge clk);
		cfg_we <= 1'b0;
		regs_shadow = s;
	endtask

	// sender pauses until every predicted beat has come back
	task automatic drain();
		while (tick_q.size() != 0 || s_axis_tvalid || tick_results_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// input driver: predicts each beat as it is taken
	always @(posedge clk) begin : drive
		logic taken;
		logic nv;
		in_item_t nxt;
		taken = s_axis_tvalid && s_axis_tready;
		if (taken)
			tick_results_q.insert(tick_results_q.size(), regulate_tick(cur_tick));
		nv = s_axis_tvalid && !taken;
		if (!nv && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (tick_q.size() != 0) begin
				if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
					gap_left = $urandom_range(1, 3) - 1;
				end else begin
					nxt = tick_q.pop_front();
					cur_tick = nxt;
					nv = 1'b1;
					s_axis_tdata <= {nxt.right_target, nxt.left_target,
						nxt.right_temp, nxt.left_temp,
						nxt.press_r3, nxt.press_r2, nxt.press_r1, nxt.press_r0,
						nxt.press_l3, nxt.press_l2, nxt.press_l1, nxt.press_l0};
				end
			end
		end
		s_axis_tvalid <= nv;
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// output monitor and receiver stalls
	always @(posedge clk) begin : watch
		out_item_t want;
		logic stall;
		if (m_axis_tvalid && m_axis_tready) begin
			beats_seen++;
			if (tick_results_q.size() == 0) begin
				flag_mismatch("result beat with nothing expected", 0, 0);
			end else begin
				want = tick_results_q.pop_front();
				if (m_axis_tdata[11:0] != want.left_total)
					flag_mismatch("left_total", m_axis_tdata[11:0], want.left_total);
				if (m_axis_tdata[23:12] != want.right_total)
					flag_mismatch("right_total", m_axis_tdata[23:12], want.right_total);
				if (m_axis_tdata[36:24] != want.grip_total)
					flag_mismatch("grip_total", m_axis_tdata[36:24], want.grip_total);
				if (m_axis_tdata[37] != want.overheated)
					flag_mismatch("overheated", m_axis_tdata[37], want.overheated);
				if (m_axis_tuser != want.cmd_kind)
					flag_mismatch("cmd_kind", m_axis_tuser, want.cmd_kind);
				if (m_axis_tdata[53:38] != want.left_goal)
					flag_mismatch("left_goal", $signed(m_axis_tdata[53:38]),
						$signed(want.left_goal));
				if (m_axis_tdata[69:54] != want.right_goal)
					flag_mismatch("right_goal", $signed(m_axis_tdata[69:54]),
						$signed(want.right_goal));
				if (m_axis_tdata[71:70] != 2'b00)
					flag_mismatch("pad bits", m_axis_tdata[71:70], 0);
			end
		end
		stall = 1'b0;
		if (stall_left > 0) begin
			stall_left--;
			stall = 1'b1;
		end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(1, 3) - 1;
			stall = 1'b1;
		end
		m_axis_tready <= arst_n && (hold_left == 0) && !stall;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		cfg_t s;
		int p;
		int i;
		logic quiet;

		// reset values of the register file
		s.lower_band = LOWER_BAND_RST;
		s.upper_band = UPPER_BAND_RST;
		s.left_limit = LEFT_LIMIT_RST;
		s.right_limit = RIGHT_LIMIT_RST;
		s.left_zero_sum = LEFT_ZERO_RST;
		s.right_zero_sum = RIGHT_ZERO_RST;
		s.regulate_enable = 1'b0;
		s.gripper_closed = 1'b0;
		regs_shadow = s;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 20;
		stall_pct = 20;

		// reset settings, regulation off: totals, zero floor, latch edges
		enq_tick(grip_tick(0, 0, 0, 0, 0, 0));
		enq_tick(grip_tick(1023, 1023, 255, 255, 32767, -32768));
		enq_tick(grip_tick(1023, 1023, 100, 0, 0, 0));
		enq_tick(grip_tick(10, 40, 74, 74, 0, 0));
		enq_tick(grip_tick(0, 0, 75, 0, 0, 0));
		enq_tick(grip_tick(0, 0, 0, 0, 0, 0));
		enq_tick(grip_tick(0, 0, 0, 75, 0, 0));
		enq_tick(grip_tick(0, 0, 0, 0, 0, 0));
		drain();

		// regulation on with the reset band and limits
		s.regulate_enable = 1'b1;
		s.gripper_closed = 1'b1;
		apply_setting(s);
		enq_tick(grip_tick(112, 145, 20, 20, 0, 0));          // inside band
		enq_tick(grip_tick(300, 300, 20, 20, 0, 0));          // release
		enq_tick(grip_tick(300, 300, 20, 20, 8000, -8000));   // release, both clamped
		enq_tick(grip_tick(300, 300, 20, 20, 7990, 0));       // release, one clamped
		enq_tick(grip_tick(0, 0, 20, 20, 0, 0));              // squeeze
		enq_tick(grip_tick(0, 0, 20, 20, -8000, 8000));       // squeeze, both clamped
		enq_tick(grip_tick(0, 0, 20, 20, -32768, -32768));    // most negative target
		enq_tick(grip_tick(1023, 1023, 20, 20, 32767, 32767));
		enq_tick(grip_tick(300, 300, 90, 20, 0, 0));          // overheat beats regulation
		enq_tick(grip_tick(300, 300, 90, 20, 0, 0));
		enq_tick(grip_tick(0, 0, 20, 20, 0, 0));              // latch clears, squeeze
		drain();

		// inverted band, zero and full limits
		s.lower_band = 13'd2000;
		s.upper_band = 13'd500;
		s.left_limit = '0;
		s.right_limit = 15'd32767;
		s.left_zero_sum = '0;
		s.right_zero_sum = '0;
		apply_setting(s);
		enq_tick(grip_tick(150, 150, 20, 20, 0, 0));
		enq_tick(grip_tick(0, 0, 20, 20, 0, 32767));
		enq_tick(grip_tick(1023, 1023, 20, 20, -32768, 32767));
		drain();

		// random phases, each with its own register setting
		for (p = 0; p < RAND_PHASES; p++) begin
			apply_setting(pick_setting(p));
			quiet = (p % 4 == 3) || (p >= RAND_PHASES - 2);
			gap_pct = quiet ? 0 : 25;
			stall_pct = quiet ? 0 : 25;
			for (i = 0; i < PHASE_TICKS; i++)
				enq_tick(random_tick());
			if (p == 5) begin
				// receiver holds off while ticks keep coming
				@(posedge clk);
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (tick_results_q.size() != 0)
			flag_mismatch("results never delivered", 0, tick_results_q.size());
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/gprb_pkg.sv
hw/rtl/gprb_calc.sv
hw/rtl/grip_pressure_band_regulator.sv
test/tb_top.sv
